>>> sv/packet_divert_classifier_macros.svh
// assertion macros shared by the classifier checks
`ifndef PACKET_DIVERT_CLASSIFIER_MACROS_SVH
`define PACKET_DIVERT_CLASSIFIER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pdc_pkg.sv
// types and constants of the packet divert classifier
`default_nettype none

package pdc_pkg;

  localparam int PORT_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int PROTO_W = 8;
  localparam int TYPE_W  = 8;
  localparam int IDX_W   = 8;
  localparam int SLOT_W  = 4;

  localparam logic [ADDR_W-1:0]  LOOPBACK_ADDR = 32'h0100_007F;
  localparam logic [PORT_W-1:0]  CONFIG_PORT   = 16'd8198;

  localparam logic [PROTO_W-1:0] PROTO_ICMP   = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP    = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP    = 8'd17;
  localparam logic [PROTO_W-1:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [TYPE_W-1:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [TYPE_W-1:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [TYPE_W-1:0] ICMP6_ECHO_REQ  = 8'd128;
  localparam logic [TYPE_W-1:0] ICMP6_ECHO_REP  = 8'd129;
  localparam logic [TYPE_W-1:0] ICMP6_ND_LO     = 8'd133;
  localparam logic [TYPE_W-1:0] ICMP6_ND_HI     = 8'd137;

  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;
  localparam logic VER_IPV4     = 1'b0;
  localparam logic VER_IPV6     = 1'b1;
  localparam logic TBL_TCP      = 1'b0;
  localparam logic TBL_UDP      = 1'b1;

  typedef enum logic [1:0] {
    V_ACCEPT = 2'd0,
    V_DROP   = 2'd1,
    V_DIVERT = 2'd2,
    V_CONFIG = 2'd3
  } pdc_verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_EMIT
  } pdc_state_e;

  // port lookup token that walks along the cell row
  typedef struct packed {
    logic              valid;
    logic              is_udp;
    logic              done;
    logic              hit;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
  } pdc_token_t;

  // exclusion table write broadcast to the cells
  typedef struct packed {
    logic              en;
    logic              tbl;
    logic [IDX_W-1:0]  idx;
    logic [PORT_W-1:0] data;
  } pdc_write_t;

endpackage

`default_nettype wire

>>> sv/pdc_cell.sv
// one cell of the port row: a tcp and a udp table entry and a token stage
`default_nettype none

module pdc_cell (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         tcp_we_i,
  input  wire                         udp_we_i,
  input  wire [pdc_pkg::PORT_W-1:0]   wdata_i,
  input  wire                         tcp_range_i,
  input  wire                         udp_range_i,
  input  pdc_pkg::pdc_token_t         tok_i,
  output pdc_pkg::pdc_token_t         tok_o
);
  import pdc_pkg::*;

  logic [PORT_W-1:0] tcp_q;
  logic [PORT_W-1:0] udp_q;
  logic [PORT_W-1:0] entry;
  logic              in_range;
  pdc_token_t        tok_d;
  pdc_token_t        tok_q;
  logic              tok_vld_q;

  // table entry storage
  always_ff @(posedge clk_i) begin
    if (tcp_we_i) begin
      tcp_q <= wdata_i;
    end
    if (udp_we_i) begin
      udp_q <= wdata_i;
    end
  end

  // resolve the token here if the scan ends or matches at this entry
  always_comb begin
    entry    = tok_i.is_udp ? udp_q : tcp_q;
    in_range = tok_i.is_udp ? udp_range_i : tcp_range_i;
    tok_d    = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (!in_range || entry == '0) begin
        tok_d.done = 1'b1;
        tok_d.hit  = 1'b0;
      end else if (entry == tok_i.sport || entry == tok_i.dport) begin
        tok_d.done = 1'b1;
        tok_d.hit  = 1'b1;
      end
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

endmodule

`default_nettype wire

>>> sv/pdc_port_chain.sv
// row of port cells: write decode, range flags and the token path
`default_nettype none

module pdc_port_chain #(
  parameter int PORT_ENTRIES = 256
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  pdc_pkg::pdc_write_t                  wr_i,
  input  wire [$clog2(PORT_ENTRIES+1)-1:0]     tcp_len_i,
  input  wire [$clog2(PORT_ENTRIES+1)-1:0]     udp_len_i,
  input  pdc_pkg::pdc_token_t                  tok_i,
  output pdc_pkg::pdc_token_t                  tok_o
);
  import pdc_pkg::*;

  localparam int LEN_W = $clog2(PORT_ENTRIES + 1);
  localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  pdc_token_t link [PORT_ENTRIES+1];

  assign link[0] = tok_i;

  // one cell per table position, token moves one cell a cycle
  for (genvar k = 0; k < PORT_ENTRIES; k++) begin : g_cell
    logic sel;
    assign sel = wr_i.en && (CMP_W'(wr_i.idx) == CMP_W'(k));

    pdc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tcp_we_i    (sel && wr_i.tbl == TBL_TCP),
      .udp_we_i    (sel && wr_i.tbl == TBL_UDP),
      .wdata_i     (wr_i.data),
      .tcp_range_i (LEN_W'(k) < tcp_len_i),
      .udp_range_i (LEN_W'(k) < udp_len_i),
      .tok_i       (link[k]),
      .tok_o       (link[k+1])
    );
  end

  assign tok_o = link[PORT_ENTRIES];

endmodule

`default_nettype wire

>>> sv/packet_divert_classifier.sv
// top level of the packet divert classifier
`default_nettype none

// Takes one transaction at a time: either a packet header to classify or a
// write into the TCP or UDP exclusion port table. Every input transaction gives
// exactly one result transaction. An accepted header or table write moves from
// the idle state through the evaluate state to the emit state, which loads the
// output register and returns to idle, where the input is ready again. An armed
// IPv4 TCP or UDP header that is not loopback needs a port lookup, which walks a
// token through the row of PORT_ENTRIES cells, one cell a cycle, in the scan
// state between evaluate and emit; that row sets the worst case. A stalled
// output holds the finished result back and keeps the input closed. No new
// transaction is taken while one is in work. Each table accepts writes until a
// write with tlast set completes it; the block is armed once both tables are
// complete.
module packet_divert_classifier #(
  parameter int PORT_ENTRIES = 256,
  parameter int RING_SLOTS   = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // protocol[7:0], src_addr[39:8], dst_addr[71:40], src_port[87:72],
  // dst_port[103:88], msg_type[111:104], entry_index[119:112],
  // port_value[135:120]
  input  wire [135:0]  s_axis_tdata_i,
  // action[0], ip_version[1], port_table[2]
  input  wire [2:0]    s_axis_tuser_i,
  // last_entry
  input  wire          s_axis_tlast_i,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // verdict[1:0], slot[5:2], armed[6], write_taken[7]
  output logic [7:0]   m_axis_tdata_o,
  // ring_select
  output logic         m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i
);
  import pdc_pkg::*;

  localparam int LEN_W  = $clog2(PORT_ENTRIES + 1);
  localparam int CMP_W  = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;
  localparam int RING_W = $clog2(RING_SLOTS);

  // held input transaction
  logic               act_q;
  logic               v6_q;
  logic [PROTO_W-1:0] proto_q;
  logic [ADDR_W-1:0]  saddr_q;
  logic [ADDR_W-1:0]  daddr_q;
  logic [PORT_W-1:0]  sport_q;
  logic [PORT_W-1:0]  dport_q;
  logic [TYPE_W-1:0]  mtype_q;
  logic               tbl_q;
  logic [IDX_W-1:0]   idx_q;
  logic [PORT_W-1:0]  pval_q;
  logic               last_q;

  pdc_state_e         state_q, state_d;
  logic               hit_q;
  logic [LEN_W-1:0]   tcp_len_q;
  logic [LEN_W-1:0]   udp_len_q;
  logic [1:0]         loaded_q;
  logic [1:0]         loaded_d;
  logic [RING_W-1:0]  ptr4_q;
  logic [RING_W-1:0]  ptr6_q;
  logic               out_vld_q;
  logic [7:0]         out_data_q;
  logic               out_user_q;

  logic               in_acc;
  logic               armed;
  logic               is_icmp, is_tcp, is_udp;
  logic               lo_any, lo_both;
  logic               needs_scan;
  logic               in_bounds;
  logic               taken;
  logic               divert;
  logic               out_free;
  logic               launch;
  logic               emit;
  logic [CMP_W-1:0]   new_len;
  logic [CMP_W-1:0]   cur_len;
  logic [RING_W-1:0]  cur_ptr;
  logic [SLOT_W-1:0]  slot;
  pdc_verdict_e       verdict;
  pdc_write_t         wr;
  pdc_token_t         tok_in;
  pdc_token_t         tok_out;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= s_axis_tuser_i[0];
      v6_q    <= s_axis_tuser_i[1];
      tbl_q   <= s_axis_tuser_i[2];
      proto_q <= s_axis_tdata_i[7:0];
      saddr_q <= s_axis_tdata_i[39:8];
      daddr_q <= s_axis_tdata_i[71:40];
      sport_q <= s_axis_tdata_i[87:72];
      dport_q <= s_axis_tdata_i[103:88];
      mtype_q <= s_axis_tdata_i[111:104];
      idx_q   <= s_axis_tdata_i[119:112];
      pval_q  <= s_axis_tdata_i[135:120];
      last_q  <= s_axis_tlast_i;
    end
  end

  // header decode
  assign armed   = &loaded_q;
  assign is_icmp = proto_q == PROTO_ICMP;
  assign is_tcp  = proto_q == PROTO_TCP;
  assign is_udp  = proto_q == PROTO_UDP;
  assign lo_any  = saddr_q == LOOPBACK_ADDR || daddr_q == LOOPBACK_ADDR;
  assign lo_both = saddr_q == LOOPBACK_ADDR && daddr_q == LOOPBACK_ADDR;

  assign needs_scan = act_q == ACT_CLASSIFY && v6_q == VER_IPV4 && armed &&
                      (is_tcp || is_udp) && !lo_any;

  // verdict from header, arming and lookup result
  always_comb begin
    verdict = V_ACCEPT;
    if (act_q == ACT_WRITE) begin
      verdict = V_ACCEPT;
    end else if (v6_q == VER_IPV6) begin
      if (armed) begin
        if (proto_q == PROTO_ICMPV6) begin
          if (mtype_q == ICMP6_ECHO_REQ || mtype_q == ICMP6_ECHO_REP) begin
            verdict = V_DIVERT;
          end else if (mtype_q inside {[ICMP6_ND_LO:ICMP6_ND_HI]}) begin
            verdict = V_ACCEPT;
          end else begin
            verdict = V_DROP;
          end
        end else if (is_tcp || is_udp) begin
          verdict = V_DIVERT;
        end else begin
          verdict = V_DROP;
        end
      end
    end else if (!(is_icmp || is_tcp || is_udp)) begin
      verdict = V_DROP;
    end else if (!armed) begin
      if (is_udp && lo_both && dport_q == CONFIG_PORT) begin
        verdict = V_CONFIG;
      end
    end else if (lo_any) begin
      verdict = V_ACCEPT;
    end else if (is_icmp) begin
      verdict = (mtype_q == ICMP_ECHO_REPLY || mtype_q == ICMP_ECHO_REQ) ? V_DIVERT : V_DROP;
    end else begin
      verdict = hit_q ? V_ACCEPT : V_DIVERT;
    end
  end

  assign divert = verdict == V_DIVERT;

  // table write bookkeeping
  assign cur_len   = (tbl_q == TBL_UDP) ? CMP_W'(udp_len_q) : CMP_W'(tcp_len_q);
  assign new_len   = CMP_W'(idx_q) + CMP_W'(1);
  assign in_bounds = CMP_W'(idx_q) < CMP_W'(PORT_ENTRIES);
  assign taken     = act_q == ACT_WRITE && !loaded_q[tbl_q] && in_bounds;

  always_comb begin
    loaded_d = loaded_q;
    if (taken && last_q) begin
      loaded_d[tbl_q] = 1'b1;
    end
  end

  assign cur_ptr = (v6_q == VER_IPV6) ? ptr6_q : ptr4_q;
  assign slot    = divert ? SLOT_W'(cur_ptr) : '0;

  // sequencer next state
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    launch          = 1'b0;
    emit            = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (needs_scan) begin
          launch  = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (tok_out.valid) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // lookup result from the end of the row
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && tok_out.valid) begin
      hit_q <= tok_out.hit;
    end
  end

  // table lengths, load flags and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcp_len_q <= '0;
      udp_len_q <= '0;
      loaded_q  <= '0;
      ptr4_q    <= '0;
      ptr6_q    <= '0;
    end else if (emit) begin
      loaded_q <= loaded_d;
      if (taken && new_len > cur_len) begin
        if (tbl_q == TBL_UDP) begin
          udp_len_q <= LEN_W'(new_len);
        end else begin
          tcp_len_q <= LEN_W'(new_len);
        end
      end
      if (divert) begin
        if (v6_q == VER_IPV6) begin
          ptr6_q <= (ptr6_q == RING_W'(RING_SLOTS - 1)) ? '0 : ptr6_q + RING_W'(1);
        end else begin
          ptr4_q <= (ptr4_q == RING_W'(RING_SLOTS - 1)) ? '0 : ptr4_q + RING_W'(1);
        end
      end
    end
  end

  // port cell row
  always_comb begin
    wr.en   = emit && taken;
    wr.tbl  = tbl_q;
    wr.idx  = idx_q;
    wr.data = pval_q;

    tok_in.valid  = launch;
    tok_in.is_udp = is_udp;
    tok_in.done   = 1'b0;
    tok_in.hit    = 1'b0;
    tok_in.sport  = sport_q;
    tok_in.dport  = dport_q;
  end

  pdc_port_chain #(
    .PORT_ENTRIES (PORT_ENTRIES)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .tcp_len_i (tcp_len_q),
    .udp_len_i (udp_len_q),
    .tok_i     (tok_in),
    .tok_o     (tok_out)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {taken, &loaded_d, slot, verdict};
      out_user_q <= divert && v6_q == VER_IPV6;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

>>> sv/pdc_checker.sv
// port-level checks of the classifier and their bind
`default_nettype none

`include "packet_divert_classifier_macros.svh"

module pdc_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire [7:0]    m_axis_tdata_o,
  input  wire          m_axis_tuser_o,
  input  wire          m_axis_tvalid_o,
  input  wire          m_axis_tready_i
);
  import pdc_pkg::*;

  logic [1:0] verdict;
  logic [3:0] slot;
  logic       armed;
  logic       taken;

  assign verdict = m_axis_tdata_o[1:0];
  assign slot    = m_axis_tdata_o[5:2];
  assign armed   = m_axis_tdata_o[6];
  assign taken   = m_axis_tdata_o[7];

  // a stalled result transaction holds
  `PDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // only a divert carries a ring and a slot
  `PDC_ASSERT_NOW(a_slot_divert, m_axis_tvalid_o && verdict != V_DIVERT, slot == 4'd0 && !m_axis_tuser_o, "slot or ring without divert")

  // configuration messages exist only while unarmed
  `PDC_ASSERT_NOW(a_config_unarmed, m_axis_tvalid_o && verdict == V_CONFIG, !armed && !taken, "config verdict while armed")

  // a stored table write reports accept
  `PDC_ASSERT_NOW(a_write_accept, m_axis_tvalid_o && taken, verdict == V_ACCEPT, "write result not accept")

  // once armed, every later result stays armed
  `PDC_ASSERT_NEXT(a_armed_sticky, m_axis_tvalid_o && armed, !m_axis_tvalid_o || armed, "armed dropped")

endmodule

bind packet_divert_classifier pdc_checker u_pdc_checker (.*);

`default_nettype wire

>>> bench/packet_divert_classifier_tb.sv
// self-checking testbench of the packet divert classifier
`timescale 1ns / 1ps

module packet_divert_classifier_tb;
  import pdc_pkg::*;

  localparam int PORT_ENTRIES = 256;
  localparam int RING_SLOTS   = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = PORT_ENTRIES + 40;

  // one input transaction, split into its fields
  typedef struct {
    logic        action;
    logic        ip_version;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  msg_type;
    logic        port_table;
    logic [7:0]  entry_index;
    logic [15:0] port_value;
    logic        last_entry;
  } pdc_item_t;

  // keeps a copy of the exclusion tables and rings, checks verdicts in order
  class verdict_scoreboard;
    typedef struct {
      pdc_verdict_e verdict;
      logic         ring;
      logic [3:0]   slot;
      logic         armed;
      logic         taken;
    } outcome_t;

    logic [15:0] excl [2][PORT_ENTRIES];
    int          excl_len [2];
    bit          excl_done [2];
    int          tables_done;
    int          v4_next;
    int          v6_next;
    outcome_t    verdicts_due [$];
    int          errors;
    int          checked;

    // scan up to the length, a zero entry ends the list
    function bit port_listed(logic tbl, logic [15:0] sp, logic [15:0] dp);
      for (int i = 0; i < excl_len[tbl]; i++) begin
        if (excl[tbl][i] == 16'h0) return 1'b0;
        if (excl[tbl][i] == sp || excl[tbl][i] == dp) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_transaction(pdc_item_t it);
      outcome_t o;
      bit       armed_now;
      bit       lo_any;
      o.verdict = V_ACCEPT;
      o.ring    = 1'b0;
      o.slot    = 4'd0;
      o.taken   = 1'b0;
      armed_now = (tables_done >= 2);
      if (it.action == ACT_WRITE) begin
        // table write, stored only while that table is still open
        if (!excl_done[it.port_table]) begin
          excl[it.port_table][it.entry_index] = it.port_value;
          if (int'(it.entry_index) + 1 > excl_len[it.port_table])
            excl_len[it.port_table] = int'(it.entry_index) + 1;
          o.taken = 1'b1;
          if (it.last_entry) begin
            excl_done[it.port_table] = 1'b1;
            tables_done++;
          end
        end
      end else if (it.ip_version == VER_IPV6) begin
        // ipv6 is accepted until armed
        if (armed_now) begin
          if (it.protocol == PROTO_ICMPV6) begin
            if (it.msg_type == ICMP6_ECHO_REQ || it.msg_type == ICMP6_ECHO_REP)
              o.verdict = V_DIVERT;
            else if (it.msg_type >= ICMP6_ND_LO && it.msg_type <= ICMP6_ND_HI)
              o.verdict = V_ACCEPT;
            else
              o.verdict = V_DROP;
          end else if (it.protocol == PROTO_TCP || it.protocol == PROTO_UDP) begin
            o.verdict = V_DIVERT;
          end else begin
            o.verdict = V_DROP;
          end
          if (o.verdict == V_DIVERT) begin
            o.ring  = 1'b1;
            o.slot  = v6_next[3:0];
            v6_next = (v6_next + 1) % RING_SLOTS;
          end
        end
      end else begin
        lo_any = (it.src_addr == LOOPBACK_ADDR) || (it.dst_addr == LOOPBACK_ADDR);
        if (it.protocol != PROTO_ICMP && it.protocol != PROTO_TCP &&
            it.protocol != PROTO_UDP) begin
          o.verdict = V_DROP;
        end else if (!armed_now) begin
          if (it.protocol == PROTO_UDP && it.src_addr == LOOPBACK_ADDR &&
              it.dst_addr == LOOPBACK_ADDR && it.dst_port == CONFIG_PORT)
            o.verdict = V_CONFIG;
        end else if (lo_any) begin
          o.verdict = V_ACCEPT;
        end else if (it.protocol == PROTO_ICMP) begin
          o.verdict = (it.msg_type == ICMP_ECHO_REPLY || it.msg_type == ICMP_ECHO_REQ) ?
                      V_DIVERT : V_DROP;
        end else begin
          o.verdict = port_listed((it.protocol == PROTO_UDP) ? TBL_UDP : TBL_TCP,
                                  it.src_port, it.dst_port) ? V_ACCEPT : V_DIVERT;
        end
        if (o.verdict == V_DIVERT) begin
          o.slot  = v4_next[3:0];
          v4_next = (v4_next + 1) % RING_SLOTS;
        end
      end
      o.armed = (tables_done >= 2);
      verdicts_due.push_back(o);
    endfunction

    function void check_verdict(logic [7:0] data, logic ring);
      outcome_t e;
      checked++;
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transaction: tdata %h tuser %b", data, ring);
        return;
      end
      e = verdicts_due.pop_front();
      if (data[1:0] !== e.verdict || ring !== e.ring || data[5:2] !== e.slot ||
          data[6] !== e.armed || data[7] !== e.taken) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch on result %0d: expected verdict %s ring %0d slot %0d ",
                 checked, e.verdict.name(), e.ring, e.slot);
          $display("armed %0d taken %0d, got verdict %0d ring %b slot %0d armed %b taken %b",
                   e.armed, e.taken, data[1:0], ring, data[5:2], data[6], data[7]);
        end
      end
    endfunction

    function int due_count();
      return verdicts_due.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic [135:0] s_axis_tdata_i;
  logic [2:0]   s_axis_tuser_i;
  logic         s_axis_tlast_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [7:0]   m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;

  verdict_scoreboard sb = new;
  bit                quiet;
  logic [15:0]       stim_vals [2][PORT_ENTRIES];
  int                stim_len [2];
  int                hold_at [2] = '{60, 900};

  packet_divert_classifier #(
    .PORT_ENTRIES (PORT_ENTRIES),
    .RING_SLOTS   (RING_SLOTS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // random values of field width
  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic rand1();
    return 1'($urandom_range(0, 1));
  endfunction

  // header transaction, table fields carry noise
  function automatic pdc_item_t header_item(logic ver, logic [7:0] proto,
                                            logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [7:0] mt);
    pdc_item_t it;
    it.action      = ACT_CLASSIFY;
    it.ip_version  = ver;
    it.protocol    = proto;
    it.src_addr    = sa;
    it.dst_addr    = da;
    it.src_port    = sp;
    it.dst_port    = dp;
    it.msg_type    = mt;
    it.port_table  = rand1();
    it.entry_index = rand8();
    it.port_value  = rand16();
    it.last_entry  = rand1();
    return it;
  endfunction

  // table write transaction, header fields carry noise
  function automatic pdc_item_t write_item(logic tbl, logic [7:0] idx, logic [15:0] val,
                                           logic last);
    pdc_item_t it;
    it.action      = ACT_WRITE;
    it.ip_version  = rand1();
    it.protocol    = rand8();
    it.src_addr    = $urandom;
    it.dst_addr    = $urandom;
    it.src_port    = rand16();
    it.dst_port    = rand16();
    it.msg_type    = rand8();
    it.port_table  = tbl;
    it.entry_index = idx;
    it.port_value  = val;
    it.last_entry  = last;
    return it;
  endfunction

  function automatic logic [15:0] nonzero_port();
    case ($urandom_range(0, 9))
      0:       return 16'h0001;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // a port that sits somewhere in the written part of a table
  function automatic logic [15:0] listed_port(logic tbl);
    if (stim_len[tbl] == 0) return rand16();
    return stim_vals[tbl][$urandom_range(0, stim_len[tbl] - 1)];
  endfunction

  // random header, weighted toward the cases that reach deep rules
  function automatic pdc_item_t rand_header();
    int          pick;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  mt;
    logic [7:0]  proto;
    logic        ver;
    sa    = $urandom;
    da    = $urandom;
    sp    = rand16();
    dp    = rand16();
    mt    = rand8();
    proto = rand8();
    ver   = VER_IPV4;
    pick  = $urandom_range(0, 99);
    if (pick < 35) begin
      proto = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1))
          sp = listed_port((proto == PROTO_UDP) ? TBL_UDP : TBL_TCP);
        else
          dp = listed_port((proto == PROTO_UDP) ? TBL_UDP : TBL_TCP);
      end
    end else if (pick < 45) begin
      // near the configuration message
      proto = PROTO_UDP;
      if ($urandom_range(0, 4) != 0) sa = LOOPBACK_ADDR;
      if ($urandom_range(0, 4) != 0) da = LOOPBACK_ADDR;
      if ($urandom_range(0, 9) < 7) dp = CONFIG_PORT;
    end else if (pick < 55) begin
      proto = PROTO_ICMP;
      case ($urandom_range(0, 2))
        0: mt = ICMP_ECHO_REPLY;
        1: mt = ICMP_ECHO_REQ;
        default: ;
      endcase
    end else if (pick < 62) begin
      case ($urandom_range(0, 2))
        0: proto = PROTO_ICMP;
        1: proto = PROTO_TCP;
        default: proto = PROTO_UDP;
      endcase
      if ($urandom_range(0, 1)) sa = LOOPBACK_ADDR;
      else da = LOOPBACK_ADDR;
    end else if (pick < 70) begin
      ver = VER_IPV4;
    end else begin
      ver = VER_IPV6;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          proto = PROTO_ICMPV6;
          case ($urandom_range(0, 5))
            0: mt = ICMP6_ECHO_REQ;
            1: mt = ICMP6_ECHO_REP;
            2: mt = 8'($urandom_range(ICMP6_ND_LO, ICMP6_ND_HI));
            3: mt = $urandom_range(0, 1) ? ICMP6_ND_LO - 8'd1 : ICMP6_ND_HI + 8'd1;
            default: ;
          endcase
        end
        4, 5, 6: proto = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
        default: ;
      endcase
    end
    return header_item(ver, proto, sa, da, sp, dp, mt);
  endfunction

  // offer one transaction and wait until it is taken, then maybe pause
  task automatic send_item(input pdc_item_t it);
    int gap;
    @(negedge clk_i);
    s_axis_tdata_i  = {it.port_value, it.entry_index, it.msg_type, it.dst_port,
                       it.src_port, it.dst_addr, it.src_addr, it.protocol};
    s_axis_tuser_i  = {it.port_table, it.ip_version, it.action};
    s_axis_tlast_i  = it.last_entry;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transaction(it);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // fill a table from entry 0 up, with headers and rewrites in between
  task automatic load_table(input logic tbl, input int n, input int zero_at);
    int          i;
    int          j;
    logic [15:0] v;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) send_item(rand_header());
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        j = $urandom_range(0, i - 1);
        v = (j == zero_at) ? 16'h0 : nonzero_port();
        stim_vals[tbl][j] = v;
        send_item(write_item(tbl, j[7:0], v, 1'b0));
      end
      v = (i == zero_at) ? 16'h0 : nonzero_port();
      stim_vals[tbl][i] = v;
      stim_len[tbl]     = i + 1;
      send_item(write_item(tbl, i[7:0], v, i == n - 1));
    end
  endtask

  // result side: random stalls plus two long hold-offs
  initial begin
    int hold_idx;
    hold_idx        = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_idx < 2 && sb.checked >= hold_at[hold_idx]) begin
        m_axis_tready_i = 1'b0;
        hold_idx++;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_verdict(m_axis_tdata_o, m_axis_tuser_o);
  end

  // stop a hung run, far beyond the slowest correct one
  initial begin
    #(15_000_000);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int n;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tvalid_i = 1'b0;
    quiet           = 1'b0;
    stim_len        = '{0, 0};
    rst_ni          = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unarmed headers
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ECHO_REQ));
    send_item(header_item(VER_IPV6, PROTO_TCP, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(header_item(VER_IPV4, PROTO_ICMP, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF,
                          ICMP_ECHO_REQ));
    send_item(header_item(VER_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0,
                          8'hFF));
    send_item(header_item(VER_IPV4, PROTO_UDP, LOOPBACK_ADDR, LOOPBACK_ADDR, 16'h0,
                          CONFIG_PORT, 8'h0));
    send_item(header_item(VER_IPV4, PROTO_UDP, LOOPBACK_ADDR, LOOPBACK_ADDR, CONFIG_PORT,
                          CONFIG_PORT + 16'd1, 8'h0));
    send_item(header_item(VER_IPV4, PROTO_UDP, LOOPBACK_ADDR, $urandom, 16'h0,
                          CONFIG_PORT, 8'h0));
    send_item(header_item(VER_IPV4, PROTO_UDP, $urandom, LOOPBACK_ADDR, 16'h0,
                          CONFIG_PORT, 8'h0));
    send_item(header_item(VER_IPV4, 8'h00, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(header_item(VER_IPV4, 8'hFF, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(header_item(VER_IPV4, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ECHO_REQ));

    // short tcp table with a zero entry in the middle
    load_table(TBL_TCP, 12, 6);

    // one table loaded: still unarmed, later tcp writes are ignored
    for (n = 0; n < 40; n++) begin
      if ($urandom_range(0, 1))
        send_item(write_item(TBL_TCP, rand8(), rand16(), rand1()));
      else
        send_item(rand_header());
    end

    // full udp table arms the block
    load_table(TBL_UDP, PORT_ENTRIES, -1);

    // armed headers
    send_item(header_item(VER_IPV4, PROTO_UDP, LOOPBACK_ADDR, LOOPBACK_ADDR, 16'h0,
                          CONFIG_PORT, 8'h0));
    send_item(header_item(VER_IPV4, PROTO_TCP, LOOPBACK_ADDR, $urandom, rand16(),
                          rand16(), 8'h0));
    send_item(header_item(VER_IPV4, PROTO_ICMP, $urandom, LOOPBACK_ADDR, rand16(),
                          rand16(), 8'd3));
    send_item(header_item(VER_IPV4, PROTO_ICMP, $urandom, $urandom, rand16(), rand16(),
                          ICMP_ECHO_REPLY));
    send_item(header_item(VER_IPV4, PROTO_ICMP, $urandom, $urandom, rand16(), rand16(),
                          ICMP_ECHO_REQ));
    send_item(header_item(VER_IPV4, PROTO_ICMP, $urandom, $urandom, rand16(), rand16(),
                          8'hFF));
    send_item(header_item(VER_IPV4, PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002,
                          stim_vals[TBL_TCP][2], 16'h0, 8'h0));
    send_item(header_item(VER_IPV4, PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002, 16'h0,
                          stim_vals[TBL_TCP][8], 8'h0));
    send_item(header_item(VER_IPV4, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0002, 16'h0,
                          stim_vals[TBL_UDP][PORT_ENTRIES - 1], 8'h0));
    send_item(header_item(VER_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,
                          16'h0, 8'h0));
    send_item(header_item(VER_IPV4, 8'd2, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ECHO_REQ));
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ECHO_REP));
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ND_LO));
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ND_HI));
    send_item(header_item(VER_IPV6, PROTO_ICMPV6, $urandom, $urandom, rand16(), rand16(),
                          ICMP6_ND_LO - 8'd1));
    send_item(header_item(VER_IPV6, PROTO_UDP, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(header_item(VER_IPV6, 8'h00, $urandom, $urandom, rand16(), rand16(),
                          rand8()));
    send_item(write_item(TBL_UDP, 8'h00, 16'hFFFF, 1'b1));

    // armed random traffic, the tail without any idling
    for (n = 0; n < 1100; n++) begin
      quiet = (n >= 950);
      if ($urandom_range(0, 9) == 0)
        send_item(write_item(rand1(), rand8(), rand16(), rand1()));
      else
        send_item(rand_header());
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    // drain, then watch for stray results
    while (sb.due_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
